// ===== hdl/naive_pattern_matcher_assert.svh =====
// Assertion macros shared by the pattern matcher RTL.
`ifndef NAIVE_PATTERN_MATCHER_ASSERT_SVH
`define NAIVE_PATTERN_MATCHER_ASSERT_SVH

// Property checked on every rising edge of clk_i, masked while rst_ni is low.
`define NPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pattern matcher assertion failed");

// Same-cycle implication.
`define NPM_ASSERT_IMPLIES(lbl, cond, conseq) \
  `NPM_ASSERT(lbl, (cond) |-> (conseq))

`endif

// ===== hdl/npm_pkg.sv =====
// Types and constants of the naive pattern matcher.
package npm_pkg;

  localparam int WIN_DEPTH = 16;
  localparam int LEN_W     = 5;
  localparam int POS_W     = 16;
  localparam int COUNT_W   = 20;

  localparam logic [7:0]         NUL_CHAR  = 8'h00;
  localparam logic [POS_W-1:0]   POS_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } match_status_e;

  typedef struct packed {
    logic [LEN_W-1:0]              pattern_length;
    logic [WIN_DEPTH-1:0][7:0]     pattern_bytes;
  } cfg_t;

  typedef struct packed {
    logic             full_match;
    logic [LEN_W-1:0] prefix_len;
  } cmp_t;

  typedef struct packed {
    match_status_e      status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ===== hdl/npm_cfg_regs.sv =====
// Configuration registers: pattern length and pattern bytes.
module npm_cfg_regs import npm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output cfg_t        cfg_o
);

  logic [LEN_W-1:0] len_q, len_d;
  logic [63:0]      low_q, low_d, high_q, high_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d  = len_q;
    low_d  = low_q;
    high_d = high_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LENGTH: len_d  = cfg_data_i[LEN_W-1:0];
        CFG_PATTERN_LOW:    low_d  = cfg_data_i;
        CFG_PATTERN_HIGH:   high_d = cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else begin
      len_q  <= len_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign cfg_o.pattern_length = len_q;
  assign cfg_o.pattern_bytes  = {high_q, low_q};

endmodule

// ===== hdl/npm_align_cmp.sv =====
// Parallel compare of the newest alignment in the window against the pattern.
module npm_align_cmp import npm_pkg::*; (
  input  logic [WIN_DEPTH-1:0][7:0] window_i,
  input  logic [WIN_DEPTH-1:0][7:0] pattern_i,
  input  logic [LEN_W-1:0]          len_i,
  output cmp_t                      cmp_o
);

  logic [WIN_DEPTH-1:0]       mismatch;
  logic [WIN_DEPTH-1:0][LEN_W-1:0] idx;

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      // alignment covers the len newest bytes, oldest byte first
      idx[k]      = LEN_W'(WIN_DEPTH) - len_i + LEN_W'(k);
      mismatch[k] = (LEN_W'(k) < len_i) &&
                    (window_i[idx[k][LEN_W-2:0]] != pattern_i[k]);
    end
  end

  always_comb begin
    cmp_o.prefix_len = '0;
    for (int k = WIN_DEPTH - 1; k >= 0; k--) begin
      if (mismatch[k]) begin
        cmp_o.prefix_len = LEN_W'(k);
      end
    end
    cmp_o.full_match = ~|mismatch;
  end

endmodule

// ===== hdl/npm_scan.sv =====
// Per-text scan state: window, byte count, first match and comparison total.
module npm_scan import npm_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  parameter int TEXT_LIMIT  = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] char_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int CW = $clog2(TEXT_LIMIT + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d, win_shift;
  logic [CW-1:0]             seen_q, seen_d, seen_inc;
  logic                      found_q, found_d;
  logic [POS_W-1:0]          first_q, first_d;
  logic [COUNT_W-1:0]        total_q, total_d;
  logic                      ovf_q, ovf_d;

  logic [LEN_W-1:0]   len;
  logic               term;
  cmp_t               cmp;
  logic [LEN_W-1:0]   add_n;
  logic [COUNT_W:0]   sum;
  logic [PW-1:0]      start1;

  assign len  = (cfg_i.pattern_length > LEN_W'(MAX_PATTERN)) ?
                LEN_W'(MAX_PATTERN) : cfg_i.pattern_length;
  assign term = (char_i == NUL_CHAR);

  assign win_shift = {char_i, win_q[WIN_DEPTH-1:1]};
  assign seen_inc  = seen_q + CW'(1);

  npm_align_cmp u_cmp (
    .window_i  (win_shift),
    .pattern_i (cfg_i.pattern_bytes),
    .len_i     (len),
    .cmp_o     (cmp)
  );

  assign add_n  = cmp.full_match ? len : cmp.prefix_len + LEN_W'(1);
  assign sum    = {1'b0, total_q} + (COUNT_W + 1)'(add_n);
  assign start1 = PW'(seen_inc) - PW'(len) + PW'(1);

  always_comb begin
    win_d   = win_q;
    seen_d  = seen_q;
    found_d = found_q;
    first_d = first_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    if (advance_i) begin
      if (term) begin
        seen_d  = '0;
        found_d = 1'b0;
        first_d = '0;
        total_d = '0;
        ovf_d   = 1'b0;
      end else if (!ovf_q) begin
        if (seen_q >= CW'(TEXT_LIMIT)) begin
          ovf_d = 1'b1;
        end else begin
          win_d  = win_shift;
          seen_d = seen_inc;
          if (len != '0 && !found_q && seen_inc >= CW'(len)) begin
            total_d = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
            if (cmp.full_match) begin
              found_d = 1'b1;
              first_d = (start1 > PW'(POS_MAX)) ? POS_MAX : start1[POS_W-1:0];
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (ovf_q) begin
      result_o.status   = STATUS_TOO_LONG;
      result_o.position = POS_MAX;
      result_o.count    = total_q;
    end else if (len == '0) begin
      result_o.status   = STATUS_FOUND;
      result_o.position = POS_W'(1);
      result_o.count    = '0;
    end else if (found_q) begin
      result_o.status   = STATUS_FOUND;
      result_o.position = first_q;
      result_o.count    = total_q;
    end else begin
      result_o.status   = STATUS_NOT_FOUND;
      result_o.position = '0;
      result_o.count    = total_q;
    end
  end

  // window bytes are only read once the current text has filled them
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      found_q <= 1'b0;
      first_q <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      found_q <= found_d;
      first_q <= first_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== hdl/naive_pattern_matcher.sv =====
// Naive pattern matcher top level: channel registers around the scan core.
//
// Text bytes enter on the text channel (text_valid_i/text_ready_o,
// text_char_i); a zero byte ends the text. One result per text leaves on the
// result channel (result_valid_o/result_ready_i) with match_status_o,
// match_position_o and compare_count_o. The pattern and its length are
// written over the cfg channel (index 0 length, 1 bytes 0-7, 2 bytes 8-15),
// which is always ready; write it only while no text is in flight.
// Throughput: one byte per cycle while no terminator waits on a pending result,
// set by the combinational window compare between the input register and the
// scan state. A terminator passes the input register, then the result register.
// When the receiver stalls, the result register holds; ordinary bytes keep
// flowing, and only a second terminator waits in the input register until the
// pending result transaction completes.
// Reset clears the configuration to an empty pattern and empties the text
// state and both channel registers.
`include "naive_pattern_matcher_assert.svh"

module naive_pattern_matcher import npm_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  parameter int TEXT_LIMIT  = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               text_valid_i,
  output logic               text_ready_o,
  input  logic [7:0]         text_char_i,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic [1:0]         match_status_o,
  output logic [POS_W-1:0]   match_position_o,
  output logic [COUNT_W-1:0] compare_count_o
);

  cfg_t    cfg;
  result_t scan_res;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_char_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       in_term;
  logic       advance;

  npm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  npm_scan #(
    .MAX_PATTERN (MAX_PATTERN),
    .TEXT_LIMIT  (TEXT_LIMIT)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .char_i    (in_char_q),
    .cfg_i     (cfg),
    .result_o  (scan_res)
  );

  assign in_term = (in_char_q == NUL_CHAR);
  // a terminator needs a free result slot; other bytes never wait
  assign advance = in_valid_q && (!in_term || !out_valid_q || result_ready_i);
  assign text_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (text_valid_i && text_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && in_term) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_valid_i && text_ready_o) begin
      in_char_q <= text_char_i;
    end
    if (advance && in_term) begin
      out_q <= scan_res;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign match_status_o   = out_q.status;
  assign match_position_o = out_q.position;
  assign compare_count_o  = out_q.count;

  `NPM_ASSERT_IMPLIES(a_stall_only_on_term, !text_ready_o,
    in_valid_q && in_term && out_valid_q && !result_ready_i)
  `NPM_ASSERT(a_result_from_term, $rose(result_valid_o) |-> $past(advance && in_term))
  `NPM_ASSERT_IMPLIES(a_too_long_saturates,
    result_valid_o && match_status_o == STATUS_TOO_LONG, match_position_o == POS_MAX)
  `NPM_ASSERT_IMPLIES(a_found_has_position,
    result_valid_o && match_status_o == STATUS_FOUND, match_position_o != '0)

endmodule
